// ----- hw/rtl/u32da_pkg.sv -----
// Shared types, microcode ROM and power-of-ten table for the decimal text converter.
package u32da_pkg;

    localparam int unsigned PcW      = 3;
    localparam int unsigned PosW     = 4;
    localparam int unsigned CandW    = 35;
    localparam logic [PosW-1:0] TopPos = 4'd9;
    localparam logic [5:0]      AsciiZero = 6'd48;
    localparam logic [5:0]      AsciiNul  = 6'd0;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_TRY,
        OP_EMIT,
        OP_TERM
    } t_op;

    typedef enum logic {
        C_SEQ,
        C_POS
    } t_cond;

    // one microcode word
    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [1:0]      bsel;
        logic [PcW-1:0]  nxt;
        logic [PcW-1:0]  alt;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        t_op        op;
        logic [1:0] bsel;
        logic       go;
    } t_ctrl;

    // datapath to sequencer
    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic pos_zero;
    } t_stat;

    localparam logic [PcW-1:0] StLoad = 3'd0;
    localparam logic [PcW-1:0] StTry3 = 3'd1;
    localparam logic [PcW-1:0] StTry2 = 3'd2;
    localparam logic [PcW-1:0] StTry1 = 3'd3;
    localparam logic [PcW-1:0] StTry0 = 3'd4;
    localparam logic [PcW-1:0] StEmit = 3'd5;
    localparam logic [PcW-1:0] StTerm = 3'd6;

    // program: per decimal position, four restoring trials then emit the digit
    function automatic t_uword rom(input logic [PcW-1:0] pc);
        t_uword w;
        begin
            case (pc)
                StLoad:  w = '{OP_LOAD, C_SEQ, 2'd0, StTry3, StTry3};
                StTry3:  w = '{OP_TRY,  C_SEQ, 2'd3, StTry2, StTry2};
                StTry2:  w = '{OP_TRY,  C_SEQ, 2'd2, StTry1, StTry1};
                StTry1:  w = '{OP_TRY,  C_SEQ, 2'd1, StTry0, StTry0};
                StTry0:  w = '{OP_TRY,  C_SEQ, 2'd0, StEmit, StEmit};
                StEmit:  w = '{OP_EMIT, C_POS, 2'd0, StTry3, StTerm};
                StTerm:  w = '{OP_TERM, C_SEQ, 2'd0, StLoad, StLoad};
                default: w = '{OP_LOAD, C_SEQ, 2'd0, StLoad, StLoad};
            endcase
            return w;
        end
    endfunction

    function automatic logic [31:0] pow10(input logic [PosW-1:0] k);
        logic [31:0] p;
        begin
            case (k)
                4'd0:    p = 32'd1;
                4'd1:    p = 32'd10;
                4'd2:    p = 32'd100;
                4'd3:    p = 32'd1000;
                4'd4:    p = 32'd10000;
                4'd5:    p = 32'd100000;
                4'd6:    p = 32'd1000000;
                4'd7:    p = 32'd10000000;
                4'd8:    p = 32'd100000000;
                4'd9:    p = 32'd1000000000;
                default: p = 32'd0;
            endcase
            return p;
        end
    endfunction

endpackage

// ----- hw/rtl/uint32_to_decimal_ascii.sv -----
// Converts a 32-bit unsigned word into its decimal ASCII digits, MSD first, then a NUL marked
// with tlast that carries the character count (NUL included). Each value runs through one load
// step, four restoring trial subtractions per decimal position over ten positions through a
// single 35-bit compare/subtract unit, one emit step per position, and one terminator step.
// Leading zeros are skipped but still use their position's steps. A new word is taken only at
// the load step; the output register lets the last result wait for the sink while the next
// word is accepted.
module uint32_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [5:0] out_char, [9:6] char_count, rest zero
    output logic        m_axis_tlast    // is_last
);

    u32da_pkg::t_ctrl ctrl;
    u32da_pkg::t_stat stat;

    logic [31:0]                r_rem,     n_rem;
    logic [u32da_pkg::PosW-1:0] r_pos,     n_pos;
    logic [3:0]                 r_digit,   n_digit;
    logic                       r_started, n_started;
    logic [3:0]                 r_count,   n_count;
    logic                       r_ovalid,  n_ovalid;
    logic [5:0]                 r_ochar,   n_ochar;
    logic [3:0]                 r_ocnt,    n_ocnt;
    logic                       r_olast,   n_olast;

    logic [u32da_pkg::CandW-1:0] cand;
    logic                        ge;

    u32da_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    assign stat.in_valid = s_axis_tvalid;
    assign stat.out_free = !r_ovalid || m_axis_tready;
    assign stat.pos_zero = (r_pos == '0);

    assign s_axis_tready = (ctrl.op == u32da_pkg::OP_LOAD);

    // trial value: 10^pos times 8, 4, 2 or 1
    assign cand = {3'b000, u32da_pkg::pow10(r_pos)} << ctrl.bsel;
    assign ge   = {3'b000, r_rem} >= cand;

    always_comb begin
        n_rem     = r_rem;
        n_pos     = r_pos;
        n_digit   = r_digit;
        n_started = r_started;
        n_count   = r_count;
        n_ovalid  = r_ovalid && !m_axis_tready;
        n_ochar   = r_ochar;
        n_ocnt    = r_ocnt;
        n_olast   = r_olast;
        if (ctrl.go) begin
            case (ctrl.op)
                u32da_pkg::OP_LOAD: begin
                    n_rem     = s_axis_tdata;
                    n_pos     = u32da_pkg::TopPos;
                    n_digit   = '0;
                    n_started = 1'b0;
                    n_count   = '0;
                end
                u32da_pkg::OP_TRY: begin
                    if (ge) begin
                        n_rem   = r_rem - cand[31:0];
                        n_digit = r_digit | (4'b0001 << ctrl.bsel);
                    end
                end
                u32da_pkg::OP_EMIT: begin
                    // skip leading zeros, but the units digit always goes out
                    if (r_digit != '0 || r_started || r_pos == '0) begin
                        n_ovalid  = 1'b1;
                        n_ochar   = u32da_pkg::AsciiZero + {2'b00, r_digit};
                        n_ocnt    = '0;
                        n_olast   = 1'b0;
                        n_started = 1'b1;
                        n_count   = r_count + 4'd1;
                    end
                    n_pos   = r_pos - 4'd1;
                    n_digit = '0;
                end
                u32da_pkg::OP_TERM: begin
                    n_ovalid = 1'b1;
                    n_ochar  = u32da_pkg::AsciiNul;
                    n_ocnt   = r_count + 4'd1;
                    n_olast  = 1'b1;
                end
                default: begin
                    n_rem = r_rem;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
        end
        r_rem     <= n_rem;
        r_pos     <= n_pos;
        r_digit   <= n_digit;
        r_started <= n_started;
        r_count   <= n_count;
        r_ochar   <= n_ochar;
        r_ocnt    <= n_ocnt;
        r_olast   <= n_olast;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'b000000, r_ocnt, r_ochar};
    assign m_axis_tlast  = r_olast;

endmodule

// ----- hw/rtl/u32da_seq.sv -----
// Microcode sequencer: step counter, control ROM and jump logic.
module u32da_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  u32da_pkg::t_stat i_stat,
    output u32da_pkg::t_ctrl o_ctrl
);

    logic [u32da_pkg::PcW-1:0] r_pc;
    logic [u32da_pkg::PcW-1:0] n_pc;
    u32da_pkg::t_uword         uw;
    logic                      go;

    always_comb begin
        uw = u32da_pkg::rom(r_pc);
        case (uw.op)
            u32da_pkg::OP_LOAD: go = i_stat.in_valid;
            u32da_pkg::OP_EMIT,
            u32da_pkg::OP_TERM: go = i_stat.out_free;
            default:            go = 1'b1;
        endcase
        n_pc = r_pc;
        if (go) begin
            case (uw.cond)
                u32da_pkg::C_POS: n_pc = i_stat.pos_zero ? uw.alt : uw.nxt;
                default:          n_pc = uw.nxt;
            endcase
        end
    end

    assign o_ctrl = '{op: uw.op, bsel: uw.bsel, go: go};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= u32da_pkg::StLoad;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ----- test/decimal_text_checker.sv -----
// Checker for the decimal text converter: predicts each value's characters and compares them.
`timescale 1ns / 100ps

module decimal_text_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_value_valid,
    input  logic        i_value_ready,
    input  logic [31:0] i_value,        // [31:0] value
    input  logic        i_char_valid,
    input  logic        i_char_ready,
    input  logic [15:0] i_char_data,    // [5:0] out_char, [9:6] char_count, rest zero
    input  logic        i_char_last,    // is_last
    output int          o_fail_count,
    output int          o_pending,
    output int          o_values,
    output int          o_chars
);

    typedef struct {
        logic [5:0] ch;
        logic       last;
        logic [3:0] count;
    } t_char_exp;

    t_char_exp expected_chars[$];
    int        fail_count   = 0;
    int        value_count  = 0;
    int        char_count   = 0;
    int        pending      = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_values     = value_count;
    assign o_chars      = char_count;

    // queue the digits MSD first, then the NUL carrying the total length
    function automatic void push_decimal_text(input logic [31:0] v);
        logic [3:0]  digs [10];
        logic [31:0] rest;
        int          nd;
        int          k;
        t_char_exp   e;
        rest = v;
        nd   = 0;
        do begin
            digs[nd] = 4'(rest % 32'd10);
            rest     = rest / 32'd10;
            nd++;
        end while (rest != 32'd0);
        for (k = nd - 1; k >= 0; k--) begin
            e.ch    = u32da_pkg::AsciiZero + 6'(digs[k]);
            e.last  = 1'b0;
            e.count = 4'd0;
            expected_chars.push_back(e);
        end
        e.ch    = u32da_pkg::AsciiNul;
        e.last  = 1'b1;
        e.count = 4'(nd + 1);
        expected_chars.push_back(e);
    endfunction

    always @(posedge i_clk) begin
        t_char_exp e;
        if (i_rst_n) begin
            // compare before queuing, so a stray word never matches a fresh value
            if (i_char_valid && i_char_ready) begin
                char_count++;
                if (expected_chars.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected word tdata=%h tlast=%b",
                                 $realtime, i_char_data, i_char_last);
                end else begin
                    e = expected_chars.pop_front();
                    if (i_char_data[5:0] !== e.ch || i_char_last !== e.last ||
                        i_char_data[9:6] !== e.count || i_char_data[15:10] !== 6'd0) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: mismatch char exp %0d got %0d, last exp %b got %b,",
                                      " count exp %0d got %0d, pad %h"},
                                     $realtime, e.ch, i_char_data[5:0], e.last, i_char_last,
                                     e.count, i_char_data[9:6], i_char_data[15:10]);
                    end
                end
            end
            if (i_value_valid && i_value_ready) begin
                value_count++;
                push_decimal_text(i_value);
            end
        end
        pending = expected_chars.size();
    end

endmodule

// ----- test/tb_uint32_to_decimal_ascii.sv -----
// Testbench top for the decimal text converter: stimulus, handshake pressure and verdict.
`timescale 1ns / 100ps

module tb_uint32_to_decimal_ascii;

    localparam int NumCorners  = 22;
    localparam int PerPhase    = 110;
    localparam int TailCycles  = 64;

    localparam logic [31:0] CornerValues [NumCorners] = '{
        32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd42, 32'd99, 32'd100, 32'd101,
        32'd65535, 32'd65536, 32'd999999999, 32'd1000000000, 32'd1000000001,
        32'd1234567890, 32'd2147483647, 32'd2147483648, 32'd4000000000,
        32'h55555555, 32'hAAAAAAAA, 32'd4294967294, 32'd4294967295
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = 32'd0;   // [31:0] value
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // [5:0] out_char, [9:6] char_count, rest zero
    logic        m_axis_tlast;            // is_last

    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int          fail_count;
    int          pending;
    int          value_count;
    int          char_count;
    int          ph;

    always #2 i_clk = ~i_clk;

    uint32_to_decimal_ascii dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    decimal_text_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value_valid (s_axis_tvalid),
        .i_value_ready (s_axis_tready),
        .i_value       (s_axis_tdata),
        .i_char_valid  (m_axis_tvalid),
        .i_char_ready  (m_axis_tready),
        .i_char_data   (m_axis_tdata),
        .i_char_last   (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_values      (value_count),
        .o_chars       (char_count)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // mostly a random digit count, with hits near powers of ten and some raw 32-bit words
    function automatic logic [31:0] pick_value();
        int unsigned kind;
        int unsigned ndig;
        int          k;
        logic [63:0] lo;
        logic [63:0] hi;
        kind = $urandom_range(9);
        ndig = $urandom_range(1, 10);
        lo   = 64'd1;
        for (k = 1; k < ndig; k++)
            lo = lo * 64'd10;
        hi = lo * 64'd10 - 64'd1;
        if (hi > 64'hFFFF_FFFF)
            hi = 64'hFFFF_FFFF;
        if (ndig == 1)
            lo = 64'd0;
        case (kind)
            0, 1:    return $urandom;
            2:       return 32'(lo) + $urandom_range(2);
            3:       return 32'(hi) - $urandom_range(2);
            default: return 32'(lo) + $urandom_range(32'(hi - lo));
        endcase
    endfunction

    // call on a rising edge; returns on the edge where the word is taken
    task automatic send_value(input logic [31:0] v);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (CornerValues[i])
            send_value(CornerValues[i]);
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 48; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 48; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            repeat (PerPhase)
                send_value(pick_value());
        end
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);
        $display("Converted %0d values into %0d characters, checked against the predicted text,",
                 value_count, char_count);
        $display("under no idling, sender gaps, receiver stalls and both at once.");
        if (fail_count == 0 && pending == 0)
            $display("tb_uint32_to_decimal_ascii passed");
        else
            $display("tb_uint32_to_decimal_ascii failed");
        $finish;
    end

    initial begin
        #1000000;
        $display("tb_uint32_to_decimal_ascii failed");
        $finish;
    end

endmodule
